>>> rtl/bal_pkg.sv
`timescale 1ns / 1ps

package bal_pkg;

    // Default list geometry.
    localparam int CAPACITY_DEFAULT   = 128;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Command codes carried by an item.
    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_POP_FIRST = 3'd2,
        CMD_POP_LAST  = 3'd3,
        CMD_POP_AT    = 3'd4,
        CMD_GET       = 3'd5,
        CMD_SEARCH    = 3'd6,
        CMD_CLEAR     = 3'd7
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Result flags handed from the sequencer to the port formatting.
    typedef struct packed {
        logic    done;
        status_t status;
        logic    hit;
    } res_flags_t;

endpackage

>>> rtl/bal_mem.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read entry store with registered read data.
module bal_mem #(
    parameter int DEPTH = bal_pkg::CAPACITY_DEFAULT,
    parameter int WIDTH = bal_pkg::DATA_WIDTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/bal_seq.sv
`timescale 1ns / 1ps

// Command sequencer. One address pointer and one compare unit walk the entry
// store a word per cycle for insert, remove, get and search.
module bal_seq #(
    parameter int CAPACITY   = bal_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH_DEFAULT,
    parameter int IW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  bal_pkg::cmd_t          cmd,
    input  logic [6:0]             position,
    input  logic [DATA_WIDTH-1:0]  word,
    output logic                   busy,
    output logic                   mem_we,
    output logic [IW-1:0]          mem_waddr,
    output logic [DATA_WIDTH-1:0]  mem_wdata,
    output logic                   mem_re,
    output logic [IW-1:0]          mem_raddr,
    input  logic [DATA_WIDTH-1:0]  mem_rdata,
    output bal_pkg::res_flags_t    res,
    output logic [DATA_WIDTH-1:0]  res_word,
    output logic [IW-1:0]          res_index,
    output logic [CW-1:0]          res_count
);

    localparam int PW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        MODE_INS  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_SRCH = 2'd2
    } mode_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    bal_pkg::cmd_t          cmd_reg, cmd_next;
    bal_pkg::status_t       status_reg, status_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [IW-1:0]          ptr_reg, ptr_next;
    logic [IW-1:0]          pend_addr_reg, pend_addr_next;
    logic                   pend_reg, pend_next;
    logic                   first_reg, first_next;
    logic                   done_reg, done_next;
    logic                   hit_reg, hit_next;
    logic [IW-1:0]          hidx_reg, hidx_next;
    logic [IW-1:0]          pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]  val_reg, val_next;
    logic [DATA_WIDTH-1:0]  rv_reg, rv_next;

    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          count_ext;
    logic                   full;
    logic                   empty;
    logic                   pos_bad;
    logic                   found;

    assign pos_ext   = PW'(position);
    assign count_ext = PW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_bad   = (pos_ext >= count_ext);

    // Next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rv_next        = rv_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg;
        found          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    pos_next    = IW'(position);
                    val_next    = word;
                    status_next = bal_pkg::STAT_OK;
                    rv_next     = '0;
                    hit_next    = 1'b0;
                    hidx_next   = '0;
                    pend_next   = 1'b0;
                    first_next  = 1'b1;
                    state_next  = S_FIN;
                    mode_next   = MODE_DEL;
                    ptr_next    = IW'(position);
                    rem_next    = count_reg - CW'(position);

                    case (cmd)
                        bal_pkg::CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = bal_pkg::STAT_FULL;
                            end
                        end
                        bal_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = bal_pkg::STAT_FULL;
                            end
                            else if (pos_bad)
                            begin
                                status_next = bal_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                mode_next  = MODE_INS;
                                ptr_next   = IW'(count_reg - CW'(1));
                                state_next = S_WALK;
                            end
                        end
                        bal_pkg::CMD_POP_FIRST:
                        begin
                            if (empty)
                            begin
                                status_next = bal_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                rem_next   = count_reg;
                                state_next = S_WALK;
                            end
                        end
                        bal_pkg::CMD_POP_LAST:
                        begin
                            if (empty)
                            begin
                                status_next = bal_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = IW'(count_reg - CW'(1));
                                rem_next   = CW'(1);
                                state_next = S_WALK;
                            end
                        end
                        bal_pkg::CMD_POP_AT,
                        bal_pkg::CMD_GET:
                        begin
                            if (empty)
                            begin
                                status_next = bal_pkg::STAT_EMPTY;
                            end
                            else if (pos_bad)
                            begin
                                status_next = bal_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                // A get reads only the addressed entry.
                                if (cmd == bal_pkg::CMD_GET)
                                begin
                                    rem_next = CW'(1);
                                end
                                state_next = S_WALK;
                            end
                        end
                        bal_pkg::CMD_SEARCH:
                        begin
                            if (!empty)
                            begin
                                mode_next  = MODE_SRCH;
                                ptr_next   = '0;
                                rem_next   = count_reg;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            // Clear needs no walk.
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // Consume the word read in the previous cycle.
                if (pend_reg)
                begin
                    case (mode_reg)
                        MODE_INS:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + IW'(1);
                        end
                        MODE_DEL:
                        begin
                            if (first_reg)
                            begin
                                rv_next    = mem_rdata;
                                first_next = 1'b0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pend_addr_reg - IW'(1);
                            end
                        end
                        MODE_SRCH:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                found     = 1'b1;
                                hit_next  = 1'b1;
                                hidx_next = pend_addr_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // Issue the next read, or finish once the walk is drained.
                if (found)
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
                else if (rem_reg != '0)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    rem_next       = rem_reg - CW'(1);
                    if (mode_reg == MODE_INS)
                    begin
                        ptr_next = ptr_reg - IW'(1);
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (status_reg == bal_pkg::STAT_OK)
                begin
                    case (cmd_reg)
                        bal_pkg::CMD_APPEND:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = IW'(count_reg);
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        bal_pkg::CMD_INSERT:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = pos_reg;
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        bal_pkg::CMD_POP_FIRST,
                        bal_pkg::CMD_POP_LAST,
                        bal_pkg::CMD_POP_AT:
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        bal_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        cmd_reg       <= cmd_next;
        status_reg    <= status_next;
        rem_reg       <= rem_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        first_reg     <= first_next;
        hit_reg       <= hit_next;
        hidx_reg      <= hidx_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        rv_reg        <= rv_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign res.done   = done_reg;
    assign res.status = status_reg;
    assign res.hit    = hit_reg;
    assign res_word   = rv_reg;
    assign res_index  = hidx_reg;
    assign res_count  = count_reg;

    // A result is only presented once the sequencer is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    // The fill count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // The store is never written while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("store write while idle");

    // An accepted item always makes the sequencer busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // A search hit is only reported with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (status_reg == bal_pkg::STAT_OK))
        else $error("hit reported with error status");

endmodule

>>> rtl/bounded_array_list_engine.sv
`timescale 1ns / 1ps

// Bounded array list engine: an ordered list of up to CAPACITY signed words in
// a single-read, single-write memory. An item is taken when start is high and
// busy is low; its one result appears on the result ports for exactly one
// cycle with done high, and the receiver cannot stall it. Append, clear, a
// search of an empty list and every rejected command need no walk of the
// memory, and get reads only the entry at its position. Insert at index p and
// pop at index p walk entries p to count - 1, pop first walks the whole list,
// pop last only its last entry, and search walks from entry 0 up to the first
// match, or to the end when a non-empty list holds no match. The walk reads
// the entry memory one word per cycle over the shifted or searched range. A
// new item may be started in the cycle its predecessor's result is shown.
module bounded_array_list_engine #(
    parameter int CAPACITY   = bal_pkg::CAPACITY_DEFAULT,
    parameter int DATA_WIDTH = bal_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic [6:0]         position,
    input  logic signed [31:0] operand_value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] read_value,
    output logic               hit,
    output logic [6:0]         hit_index,
    output logic [7:0]         fill_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = (IW > 7) ? IW : 7;
    localparam int FW = (CW > 8) ? CW : 8;

    logic signed [63:0]      op_ext;
    logic [DATA_WIDTH-1:0]   word_in;
    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;
    logic [DATA_WIDTH-1:0]   mem_rdata;
    bal_pkg::res_flags_t     res;
    logic [DATA_WIDTH-1:0]   res_word;
    logic [IW-1:0]           res_index;
    logic [CW-1:0]           res_count;
    logic signed [63:0]      word_ext;
    logic [HW-1:0]           index_ext;
    logic [FW-1:0]           count_ext;

    // Operand kept in the low DATA_WIDTH bits of its sign extension.
    assign op_ext  = 64'(operand_value);
    assign word_in = op_ext[DATA_WIDTH-1:0];

    bal_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (bal_pkg::cmd_t'(cmd)),
        .position  (position),
        .word      (word_in),
        .busy      (busy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_word  (res_word),
        .res_index (res_index),
        .res_count (res_count)
    );

    bal_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result formatting: sign-extend the stored word, fit index and count.
    assign word_ext  = 64'(signed'(res_word));
    assign index_ext = HW'(res_index);
    assign count_ext = FW'(res_count);

    assign done       = res.done;
    assign status     = res.status;
    assign read_value = word_ext[31:0];
    assign hit        = res.hit;
    assign hit_index  = index_ext[6:0];
    assign fill_count = count_ext[7:0];

endmodule
